// File: design/swc_pkg.sv
// Shared constants for the segment window clipper.
package swc_pkg;

    // Default coordinate width of one endpoint field.
    localparam int COORD_WIDTH = 24;

    // Width and reset value of the window limit register.
    localparam int LIMIT_WIDTH = 15;
    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 15'd5000;

endpackage

// File: design/swc_div_cell.sv
// One restoring division step of the pipelined divider chain.
module swc_div_cell #(
    parameter int PW    = 8,
    parameter int NW    = 8,
    parameter int DW    = 4,
    parameter int QW    = 4,
    parameter int SHIFT = 0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [PW-1:0] in_pay,
    input  logic [NW-1:0] in_rem,
    input  logic [DW-1:0] in_den,
    input  logic [QW-1:0] in_quo,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [PW-1:0] out_pay,
    output logic [NW-1:0] out_rem,
    output logic [DW-1:0] out_den,
    output logic [QW-1:0] out_quo
);

    logic          valid_reg;
    logic [PW-1:0] pay_reg;
    logic [NW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg;
    logic [QW-1:0] quo_reg, quo_next;
    logic [NW-1:0] shifted;

    // Trial subtraction of the divisor weighted by this cell's quotient bit.
    always_comb begin
        shifted  = NW'(in_den) << SHIFT;
        rem_next = in_rem;
        quo_next = in_quo;
        if (in_rem >= shifted) begin
            rem_next        = in_rem - shifted;
            quo_next[SHIFT] = 1'b1;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // Valid bit of this cell.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    // Data moves whenever the cell may take a new transaction.
    always_ff @(posedge aclk) begin
        if (in_ready) begin
            pay_reg <= in_pay;
            rem_reg <= rem_next;
            den_reg <= in_den;
            quo_reg <= quo_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pay   = pay_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_quo   = quo_reg;

endmodule

// File: design/swc_divider.sv
// Pipelined unsigned divider built as a row of one-bit division cells.
module swc_divider #(
    parameter int PW = 8,
    parameter int NW = 8,
    parameter int DW = 4,
    parameter int QW = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [PW-1:0] in_pay,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [PW-1:0] out_pay,
    output logic [QW-1:0] out_quo
);

    logic          vld_w [0:QW];
    logic          rdy_w [0:QW];
    logic [PW-1:0] pay_w [0:QW];
    logic [NW-1:0] rem_w [0:QW];
    logic [DW-1:0] den_w [0:QW];
    logic [QW-1:0] quo_w [0:QW];

    assign vld_w[0] = in_valid;
    assign in_ready = rdy_w[0];
    assign pay_w[0] = in_pay;
    assign rem_w[0] = in_num;
    assign den_w[0] = in_den;
    assign quo_w[0] = '0;

    // Quotient bits resolve from the most significant one downward.
    for (genvar i = 0; i < QW; i++) begin : g_cell
        swc_div_cell #(
            .PW(PW), .NW(NW), .DW(DW), .QW(QW), .SHIFT(QW - 1 - i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (vld_w[i]),
            .in_ready (rdy_w[i]),
            .in_pay   (pay_w[i]),
            .in_rem   (rem_w[i]),
            .in_den   (den_w[i]),
            .in_quo   (quo_w[i]),
            .out_valid(vld_w[i+1]),
            .out_ready(rdy_w[i+1]),
            .out_pay  (pay_w[i+1]),
            .out_rem  (rem_w[i+1]),
            .out_den  (den_w[i+1]),
            .out_quo  (quo_w[i+1])
        );
    end

    assign out_valid = vld_w[QW];
    assign rdy_w[QW] = out_ready;
    assign out_pay   = pay_w[QW];
    assign out_quo   = quo_w[QW];

endmodule

// File: design/segment_window_clipper_top.sv
// Top level of the segment window clipper: classify, clamp and divide pipeline.
//
// A segment enters on every clock unless the pipeline is full and stalled;
// most of its stages are the two divider chains, one quotient bit per cell,
// that recompute the clamped end on sloped lines. Every stage has its own
// valid bit, so gaps close up when the result side stalls, and a new segment
// is taken while a result waits if some stage is empty. Both inputs and
// outputs are stream channels; draw travels on m_tuser. The window
// limit must only be written while the block holds no segments.
module segment_window_clipper_top #(
    parameter int COORD_WIDTH = swc_pkg::COORD_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [swc_pkg::LIMIT_WIDTH-1:0] cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // start_x, start_y, end_x, end_y from the lowest bit up
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // clip_start_x, clip_start_y, clip_end_x, clip_end_y from the lowest bit up
    output logic [((4*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
    // draw
    output logic                           m_tuser
);

    localparam int CW  = COORD_WIDTH;
    localparam int DW  = CW + 1;
    localparam int NW  = 2 * DW;
    localparam int QW  = DW;
    localparam int LW  = swc_pkg::LIMIT_WIDTH;
    localparam int TDW = ((4*CW+7)/8)*8;

    typedef struct packed {
        logic signed [DW-1:0] ax;
        logic signed [DW-1:0] ay;
        logic signed [DW-1:0] bx;
        logic signed [DW-1:0] by;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic                 draw;
        logic                 sloped;
        logic                 need;
        logic                 neg;
    } rec_t;

    localparam int PW = $bits(rec_t);

    // Window limit register.
    logic [LW-1:0] limit_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= swc_pkg::LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    logic signed [DW-1:0] lim, nlim;
    assign lim  = $signed({{(DW-LW){1'b0}}, limit_reg});
    assign nlim = -lim;

    // Classify and swap; clamp the straight cases, and the x end of sloped ones.
    logic signed [DW-1:0] sx, sy, ex, ey;
    logic                 ain, bin;
    rec_t                 a_next;
    always_comb begin
        sx = $signed({s_tdata[CW-1], s_tdata[CW-1:0]});
        sy = $signed({s_tdata[2*CW-1], s_tdata[2*CW-1:CW]});
        ex = $signed({s_tdata[3*CW-1], s_tdata[3*CW-1:2*CW]});
        ey = $signed({s_tdata[4*CW-1], s_tdata[4*CW-1:3*CW]});
        ain = (sx > nlim) && (sx < lim) && (sy > nlim) && (sy < lim);
        bin = (ex > nlim) && (ex < lim) && (ey > nlim) && (ey < lim);
        a_next.ax = ain ? sx : ex;
        a_next.ay = ain ? sy : ey;
        a_next.bx = ain ? ex : sx;
        a_next.by = ain ? ey : sy;
        a_next.dx = a_next.bx - a_next.ax;
        a_next.dy = a_next.by - a_next.ay;
        a_next.draw   = ain || bin;
        a_next.sloped = 1'b0;
        a_next.need   = 1'b0;
        a_next.neg    = 1'b0;
        if (!(ain && bin)) begin
            if (a_next.dx == '0) begin
                if (a_next.by > lim) a_next.by = lim;
                else if (a_next.by < nlim) a_next.by = nlim;
            end else if (a_next.dy == '0) begin
                if (a_next.bx > lim) a_next.bx = lim;
                else if (a_next.bx < nlim) a_next.bx = nlim;
            end else begin
                a_next.sloped = 1'b1;
                if (a_next.bx > lim || a_next.bx < nlim) begin
                    a_next.need = 1'b1;
                    a_next.bx   = (a_next.bx > lim) ? lim : nlim;
                end
            end
        end
        if (!a_next.draw) begin
            a_next = '0;
        end
    end

    logic a_valid_reg, a_ready, m1_ready;
    rec_t a_rec_reg;
    assign a_ready  = !a_valid_reg || m1_ready;
    assign s_tready = a_ready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= s_tvalid;
        end
    end
    always_ff @(posedge aclk) begin
        if (a_ready) begin
            a_rec_reg <= a_next;
        end
    end

    // First product: dy * (clamped x - ax), divided by dx.
    logic signed [NW-1:0] p1;
    rec_t                 m1_rec_next;
    logic [NW-1:0]        m1_num_next;
    logic [DW-1:0]        m1_den_next;
    always_comb begin
        p1 = NW'(a_rec_reg.dy) * NW'(a_rec_reg.bx - a_rec_reg.ax);
        m1_rec_next     = a_rec_reg;
        m1_rec_next.neg = p1[NW-1] ^ a_rec_reg.dx[DW-1];
        m1_num_next     = p1[NW-1] ? NW'(-p1) : NW'(p1);
        m1_den_next     = a_rec_reg.dx[DW-1] ? DW'(-a_rec_reg.dx) : DW'(a_rec_reg.dx);
    end

    logic          m1_valid_reg, d1_ready;
    rec_t          m1_rec_reg;
    logic [NW-1:0] m1_num_reg;
    logic [DW-1:0] m1_den_reg;
    assign m1_ready = !m1_valid_reg || d1_ready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_valid_reg <= 1'b0;
        end else if (m1_ready) begin
            m1_valid_reg <= a_valid_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (m1_ready) begin
            m1_rec_reg <= m1_rec_next;
            m1_num_reg <= m1_num_next;
            m1_den_reg <= m1_den_next;
        end
    end

    logic          d1_valid, f1_ready;
    logic [PW-1:0] d1_pay;
    logic [QW-1:0] d1_quo;
    swc_divider #(.PW(PW), .NW(NW), .DW(DW), .QW(QW)) u_div1 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (m1_valid_reg),
        .in_ready (d1_ready),
        .in_pay   (m1_rec_reg),
        .in_num   (m1_num_reg),
        .in_den   (m1_den_reg),
        .out_valid(d1_valid),
        .out_ready(f1_ready),
        .out_pay  (d1_pay),
        .out_quo  (d1_quo)
    );

    // Apply the first quotient to y, then decide on the y clamp.
    rec_t                 f1_in, f1_next;
    logic signed [DW:0]   q1s;
    always_comb begin
        f1_in   = rec_t'(d1_pay);
        f1_next = f1_in;
        q1s     = f1_in.neg ? -$signed({1'b0, d1_quo}) : $signed({1'b0, d1_quo});
        if (f1_in.need) begin
            f1_next.by = DW'($signed({f1_in.ay[DW-1], f1_in.ay}) + q1s);
        end
        f1_next.need = f1_in.sloped && (f1_next.by > lim || f1_next.by < nlim);
        if (f1_next.need) begin
            f1_next.by = (f1_next.by > lim) ? lim : nlim;
        end
    end

    logic f1_valid_reg, m2_ready;
    rec_t f1_rec_reg;
    assign f1_ready = !f1_valid_reg || m2_ready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
        end else if (f1_ready) begin
            f1_valid_reg <= d1_valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (f1_ready) begin
            f1_rec_reg <= f1_next;
        end
    end

    // Second product: dx * (clamped y - ay), divided by dy.
    logic signed [NW-1:0] p2;
    rec_t                 m2_rec_next;
    logic [NW-1:0]        m2_num_next;
    logic [DW-1:0]        m2_den_next;
    always_comb begin
        p2 = NW'(f1_rec_reg.dx) * NW'(f1_rec_reg.by - f1_rec_reg.ay);
        m2_rec_next     = f1_rec_reg;
        m2_rec_next.neg = p2[NW-1] ^ f1_rec_reg.dy[DW-1];
        m2_num_next     = p2[NW-1] ? NW'(-p2) : NW'(p2);
        m2_den_next     = f1_rec_reg.dy[DW-1] ? DW'(-f1_rec_reg.dy) : DW'(f1_rec_reg.dy);
    end

    logic          m2_valid_reg, d2_ready;
    rec_t          m2_rec_reg;
    logic [NW-1:0] m2_num_reg;
    logic [DW-1:0] m2_den_reg;
    assign m2_ready = !m2_valid_reg || d2_ready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m2_valid_reg <= 1'b0;
        end else if (m2_ready) begin
            m2_valid_reg <= f1_valid_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (m2_ready) begin
            m2_rec_reg <= m2_rec_next;
            m2_num_reg <= m2_num_next;
            m2_den_reg <= m2_den_next;
        end
    end

    logic          d2_valid, f2_ready;
    logic [PW-1:0] d2_pay;
    logic [QW-1:0] d2_quo;
    swc_divider #(.PW(PW), .NW(NW), .DW(DW), .QW(QW)) u_div2 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (m2_valid_reg),
        .in_ready (d2_ready),
        .in_pay   (m2_rec_reg),
        .in_num   (m2_num_reg),
        .in_den   (m2_den_reg),
        .out_valid(d2_valid),
        .out_ready(f2_ready),
        .out_pay  (d2_pay),
        .out_quo  (d2_quo)
    );

    // Apply the second quotient to x and hold the result for the output.
    rec_t               f2_in, f2_next;
    logic signed [DW:0] q2s;
    always_comb begin
        f2_in   = rec_t'(d2_pay);
        f2_next = f2_in;
        q2s     = f2_in.neg ? -$signed({1'b0, d2_quo}) : $signed({1'b0, d2_quo});
        if (f2_in.need) begin
            f2_next.bx = DW'($signed({f2_in.ax[DW-1], f2_in.ax}) + q2s);
        end
    end

    logic f2_valid_reg;
    rec_t f2_rec_reg;
    assign f2_ready = !f2_valid_reg || m_tready;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f2_valid_reg <= 1'b0;
        end else if (f2_ready) begin
            f2_valid_reg <= d2_valid;
        end
    end
    always_ff @(posedge aclk) begin
        if (f2_ready) begin
            f2_rec_reg <= f2_next;
        end
    end

    assign m_tvalid = f2_valid_reg;
    assign m_tuser  = f2_rec_reg.draw;
    assign m_tdata  = TDW'({f2_rec_reg.by[CW-1:0], f2_rec_reg.bx[CW-1:0],
                            f2_rec_reg.ay[CW-1:0], f2_rec_reg.ax[CW-1:0]});

    // A full input stage can only come from a stall at the result side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a result stall");

    // A rejected segment carries all-zero coordinates.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("rejected segment with nonzero coordinates");

    // An accepted segment reaches the first stage on the next edge.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> a_valid_reg)
        else $error("accepted segment lost at the first stage");

endmodule

// File: test/segment_window_clipper_checker.sv
// Checker for the segment window clipper: predicts each clipped segment and compares.
`timescale 1ns / 1ps

module segment_window_clipper_checker #(
    parameter int COORD_WIDTH = swc_pkg::COORD_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [swc_pkg::LIMIT_WIDTH-1:0]     cfg_wr_data,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]  s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]  m_tdata,
    input  logic                                m_tuser,
    output int                                  error_count,
    output int                                  pending_count
);

    localparam int DW = ((4*COORD_WIDTH+7)/8)*8;

    typedef struct packed {
        logic          draw;
        logic [DW-1:0] coords;
    } clip_result_t;

    logic [swc_pkg::LIMIT_WIDTH-1:0] limit_copy;
    clip_result_t                    clipped_queue[$];

    function automatic longint field_of(logic [DW-1:0] d, int k);
        logic [COORD_WIDTH-1:0] f;
        f = d[k*COORD_WIDTH +: COORD_WIDTH];
        return longint'($signed(f));
    endfunction

    function automatic longint magnitude(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Clip one segment against the square window of half width lim.
    function automatic clip_result_t clip_segment(logic [DW-1:0] d, longint lim);
        clip_result_t r;
        longint ax, ay, bx, by, t, dx, dy;
        bit a_in, b_in;
        ax = field_of(d, 0);
        ay = field_of(d, 1);
        bx = field_of(d, 2);
        by = field_of(d, 3);
        a_in = magnitude(ax) < lim && magnitude(ay) < lim;
        b_in = magnitude(bx) < lim && magnitude(by) < lim;
        r = '0;
        if (!a_in && !b_in) return r;
        if (!(a_in && b_in)) begin
            // Put the inside end first.
            if (!a_in) begin
                t = ax; ax = bx; bx = t;
                t = ay; ay = by; by = t;
            end
            dx = bx - ax;
            dy = by - ay;
            if (dx == 0) begin
                if (by > lim) by = lim;
                else if (by < -lim) by = -lim;
            end else if (dy == 0) begin
                if (bx > lim) bx = lim;
                else if (bx < -lim) bx = -lim;
            end else begin
                if (bx > lim || bx < -lim) begin
                    bx = bx > lim ? lim : -lim;
                    by = ay + (dy * (bx - ax)) / dx;
                end
                if (by > lim || by < -lim) begin
                    by = by > lim ? lim : -lim;
                    bx = ax + (dx * (by - ay)) / dy;
                end
            end
        end
        r.draw = 1'b1;
        r.coords[0*COORD_WIDTH +: COORD_WIDTH] = ax[COORD_WIDTH-1:0];
        r.coords[1*COORD_WIDTH +: COORD_WIDTH] = ay[COORD_WIDTH-1:0];
        r.coords[2*COORD_WIDTH +: COORD_WIDTH] = bx[COORD_WIDTH-1:0];
        r.coords[3*COORD_WIDTH +: COORD_WIDTH] = by[COORD_WIDTH-1:0];
        return r;
    endfunction

    assign pending_count = clipped_queue.size();

    // Track the register, queue predictions, and compare each output transaction.
    always @(posedge aclk) begin
        clip_result_t want;
        if (!aresetn) begin
            limit_copy  <= swc_pkg::LIMIT_RESET;
            error_count <= 0;
            clipped_queue.delete();
        end else begin
            if (cfg_wr_en) limit_copy <= cfg_wr_data;
            if (s_tvalid && s_tready)
                clipped_queue.push_back(clip_segment(s_tdata, longint'(limit_copy)));
            if (m_tvalid && m_tready) begin
                if (clipped_queue.size() == 0) begin
                    if (error_count < 10)
                        $display("ERROR: unexpected result draw=%0b data=%h", m_tuser, m_tdata);
                    error_count <= error_count + 1;
                end else begin
                    want = clipped_queue.pop_front();
                    if (want.draw !== m_tuser || want.coords !== m_tdata) begin
                        if (error_count < 10)
                            $display("ERROR: expected draw=%0b data=%h, got draw=%0b data=%h",
                                     want.draw, want.coords, m_tuser, m_tdata);
                        error_count <= error_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: test/segment_window_clipper_top_test.sv
// Testbench top for the segment window clipper: stimulus, register phases and verdict.
`timescale 1ns / 1ps

module segment_window_clipper_top_test;

    localparam int CW = swc_pkg::COORD_WIDTH;
    localparam int DW = ((4*CW+7)/8)*8;
    localparam int LATENCY = 2*CW + 8;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [swc_pkg::LIMIT_WIDTH-1:0] cfg_wr_data = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [DW-1:0]                   s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [DW-1:0]                   m_tdata;
    logic                            m_tuser;
    int                              error_count;
    int                              pending_count;
    bit                              sink_steady = 1'b0;
    bit                              timed_out = 1'b0;

    always #10 aclk = ~aclk;

    segment_window_clipper_top uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    segment_window_clipper_checker checker_inst (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .error_count(error_count), .pending_count(pending_count)
    );

    // Result side stalls at random except during the steady stretch.
    always @(negedge aclk) begin
        m_tready <= sink_steady ? 1'b1 : ($urandom_range(99) >= 35);
    end

    // Send one segment as a transaction, with optional idle cycles first.
    // The valid stays high on return so that the next segment can follow directly.
    task automatic send_segment(input logic [CW-1:0] ax, ay, bx, by, input bit gaps);
        while (gaps && $urandom_range(99) < 35) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(DW-4*CW){1'b0}}, by, bx, ay, ax};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // Wait for all results to drain, then write the window limit.
    task automatic set_limit(input logic [swc_pkg::LIMIT_WIDTH-1:0] lim);
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lim;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Random coordinate, mostly near the window so that clipping cases dominate.
    function automatic logic [CW-1:0] pick_coord(int lim);
        int sel;
        sel = $urandom_range(9);
        if (sel < 6) return CW'($signed($urandom_range(4*lim)) - 2*lim);
        if (sel < 8) return CW'($urandom);
        return sel == 8 ? CW'(lim) : CW'(-lim);
    endfunction

    // Random segment; some are axis aligned to reach the single-coordinate clamps.
    task automatic random_phase(input int count, input int lim, input bit gaps);
        logic [CW-1:0] ax, ay, bx, by;
        for (int i = 0; i < count; i++) begin
            ax = pick_coord(lim); ay = pick_coord(lim);
            bx = pick_coord(lim); by = pick_coord(lim);
            case ($urandom_range(7))
                0: bx = ax;
                1: by = ay;
                default: ;
            endcase
            send_segment(ax, ay, bx, by, gaps);
        end
    endtask

    initial begin
        logic [CW-1:0] mx, mn;
        mx = {1'b0, {(CW-1){1'b1}}};
        mn = {1'b1, {(CW-1){1'b0}}};
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed cases at the reset limit.
        send_segment(0, 0, 100, -100, 1);          // both inside
        send_segment(0, 0, 0, 9000, 1);            // vertical clamp
        send_segment(0, 0, -9000, 0, 1);           // horizontal clamp
        send_segment(9000, 300, 10, 20, 1);        // swap, sloped, x clamp
        send_segment(10, 20, 300, -9000, 1);       // sloped, y clamp
        send_segment(0, 0, mx, mx, 1);             // x clamp puts y on the limit
        send_segment(-1, 1, mn, mn, 1);
        send_segment(mx, mn, mn, mx, 1);           // both outside
        send_segment(5000, 0, 0, 0, 1);            // boundary counts as outside
        send_segment(4999, -4999, 0, 0, 1);
        send_segment(0, 5000, 4999, 4999, 1);
        send_segment(-4999, 0, 0, mn, 1);

        // Smallest window: only the origin is inside.
        set_limit(1);
        send_segment(0, 0, 5, 3, 1);
        send_segment(1, 0, 0, 0, 1);
        send_segment(0, 0, mn, mx, 1);
        random_phase(60, 1, 1);

        // Largest window.
        set_limit(15'h7fff);
        send_segment(32766, -32766, mx, mn, 1);
        send_segment(mx, 5, 32766, 0, 1);
        random_phase(150, 32767, 1);

        // Zero window rejects everything.
        set_limit(0);
        random_phase(30, 100, 1);

        // Mid window with a stretch of back-to-back transactions.
        set_limit(777);
        sink_steady = 1'b1;
        random_phase(120, 777, 0);
        sink_steady = 1'b0;
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        random_phase(150, 777, 1);

        set_limit(5000);
        random_phase(130, 5000, 1);

        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (LATENCY + 10) @(negedge aclk);
        if (error_count == 0 && !timed_out)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #20ms;
        timed_out = 1'b1;
        $display("Test completed with failures");
        $finish;
    end

endmodule
